// File: hdl/md5_keystream_xor_cipher_assert.svh
// assertion macros for the md5 keystream cipher
// used by the top level only, needs clk and rst_n in scope
`ifndef MD5_KEYSTREAM_XOR_CIPHER_ASSERT_SVH
`define MD5_KEYSTREAM_XOR_CIPHER_ASSERT_SVH
`define MKX_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MKX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/mkx_pkg.sv
// shared types and constants for the md5 keystream cipher
// no dependencies
`timescale 1ns / 1ps
package mkx_pkg;
    localparam int unsigned RoundCount = 64;

    typedef logic [31:0] word_t;
    typedef logic [127:0] digest_t;

    typedef struct packed {
        logic start;
        logic key_msg;
    } md5_ctl_t;

    function automatic word_t md5_k(input logic [5:0] idx);
        word_t r;
        unique case (idx)
            6'd0: r = 32'hd76aa478; 6'd1: r = 32'he8c7b756; 6'd2: r = 32'h242070db;
            6'd3: r = 32'hc1bdceee; 6'd4: r = 32'hf57c0faf; 6'd5: r = 32'h4787c62a;
            6'd6: r = 32'ha8304613; 6'd7: r = 32'hfd469501; 6'd8: r = 32'h698098d8;
            6'd9: r = 32'h8b44f7af; 6'd10: r = 32'hffff5bb1; 6'd11: r = 32'h895cd7be;
            6'd12: r = 32'h6b901122; 6'd13: r = 32'hfd987193; 6'd14: r = 32'ha679438e;
            6'd15: r = 32'h49b40821; 6'd16: r = 32'hf61e2562; 6'd17: r = 32'hc040b340;
            6'd18: r = 32'h265e5a51; 6'd19: r = 32'he9b6c7aa; 6'd20: r = 32'hd62f105d;
            6'd21: r = 32'h02441453; 6'd22: r = 32'hd8a1e681; 6'd23: r = 32'he7d3fbc8;
            6'd24: r = 32'h21e1cde6; 6'd25: r = 32'hc33707d6; 6'd26: r = 32'hf4d50d87;
            6'd27: r = 32'h455a14ed; 6'd28: r = 32'ha9e3e905; 6'd29: r = 32'hfcefa3f8;
            6'd30: r = 32'h676f02d9; 6'd31: r = 32'h8d2a4c8a; 6'd32: r = 32'hfffa3942;
            6'd33: r = 32'h8771f681; 6'd34: r = 32'h6d9d6122; 6'd35: r = 32'hfde5380c;
            6'd36: r = 32'ha4beea44; 6'd37: r = 32'h4bdecfa9; 6'd38: r = 32'hf6bb4b60;
            6'd39: r = 32'hbebfbc70; 6'd40: r = 32'h289b7ec6; 6'd41: r = 32'heaa127fa;
            6'd42: r = 32'hd4ef3085; 6'd43: r = 32'h04881d05; 6'd44: r = 32'hd9d4d039;
            6'd45: r = 32'he6db99e5; 6'd46: r = 32'h1fa27cf8; 6'd47: r = 32'hc4ac5665;
            6'd48: r = 32'hf4292244; 6'd49: r = 32'h432aff97; 6'd50: r = 32'hab9423a7;
            6'd51: r = 32'hfc93a039; 6'd52: r = 32'h655b59c3; 6'd53: r = 32'h8f0ccc92;
            6'd54: r = 32'hffeff47d; 6'd55: r = 32'h85845dd1; 6'd56: r = 32'h6fa87e4f;
            6'd57: r = 32'hfe2ce6e0; 6'd58: r = 32'ha3014314; 6'd59: r = 32'h4e0811a1;
            6'd60: r = 32'hf7537e82; 6'd61: r = 32'hbd3af235; 6'd62: r = 32'h2ad7d2bb;
            default: r = 32'heb86d391;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] idx);
        logic [4:0] r;
        unique case (idx)
            4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
            4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
            4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction
endpackage

// File: hdl/md5_keystream_xor_cipher.sv
// md5 output-feedback keystream xor cipher, top level
// uses mkx_pkg, mkx_md5_core and md5_keystream_xor_cipher_assert.svh
//
// channel   dir  signals                       fields (low bit up)
// s_axis    in   s_axis_tvalid/tready/tdata    tdata: data_byte; tlast: last_byte
// m_axis    out  m_axis_tvalid/tready/tdata    tdata: out_byte; tlast: out_last
// cfg       in   cfg_we, cfg_data              cipher_key
//
// a beat at a nonzero group position goes straight to the output state, position 0
// first hashes the digest, a buffer's first byte the key and then that digest, one
// md5 round per cycle in the shared core; the next beat can be taken in the same
// cycle as the result appears; reset clears the sequencer, position and restarts
// from the key; the output register holds a result while m_axis_tready is low, the
// next beat then waits in the output state
`timescale 1ns / 1ps
`include "md5_keystream_xor_cipher_assert.svh"
module md5_keystream_xor_cipher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast    // out_last
);
    import mkx_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StKey  = 3'd1;
    localparam logic [2:0] StFb   = 3'd2;
    localparam logic [2:0] StWait = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [63:0] key_reg;
    digest_t     dig_reg;
    logic [3:0]  pos_reg;
    logic        start_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic        ovalid_reg;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        kphase_reg;
    md5_ctl_t    ctl;
    logic        core_done;
    digest_t     core_dig;
    logic [7:0]  ks;
    logic        out_free;

    assign s_axis_tready = (state_reg == StIdle);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign ks = dig_reg[{pos_reg, 3'b000} +: 8];

    always_comb
    begin
        ctl.start   = 1'b0;
        ctl.key_msg = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (start_reg)
                    begin
                        ctl.start   = 1'b1;
                        ctl.key_msg = 1'b1;
                        state_next  = StKey;
                    end
                    else if (pos_reg == 4'd0)
                    begin
                        ctl.start  = 1'b1;
                        state_next = StWait;
                    end
                    else
                    begin
                        state_next = StOut;
                    end
                end
            end
            StKey:
            begin
                if (core_done)
                begin
                    state_next = StFb;
                end
            end
            StFb:
            begin
                ctl.start  = 1'b1;
                state_next = StWait;
            end
            StWait:
            begin
                if (core_done)
                begin
                    state_next = StOut;
                end
            end
            StOut:
            begin
                if (out_free)
                begin
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    mkx_md5_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .msg    (ctl.key_msg ? {64'd0, key_reg} : (state_reg == StFb ? core_dig : dig_reg)),
        .done   (core_done),
        .digest (core_dig)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= StIdle;
            key_reg    <= '0;
            pos_reg    <= '0;
            start_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
            kphase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                key_reg <= cfg_data;
            end
            if (ctl.start)
            begin
                kphase_reg <= ctl.key_msg;
            end
            if (s_axis_tvalid && s_axis_tready && start_reg)
            begin
                start_reg <= 1'b0;
                pos_reg   <= '0;
            end
            if (state_reg == StOut && out_free)
            begin
                ovalid_reg <= 1'b1;
                if (last_reg)
                begin
                    start_reg <= 1'b1;
                    pos_reg   <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 4'd1;
                end
            end
            else if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            data_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (state_reg == StWait && core_done)
        begin
            dig_reg <= core_dig;
        end
        if (state_reg == StOut && out_free)
        begin
            obyte_reg <= data_reg ^ ks;
            olast_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = obyte_reg;
    assign m_axis_tlast  = olast_reg;

    `MKX_ASSERT_IMPL(a_no_accept_busy, state_reg != StIdle, !s_axis_tready)
    `MKX_ASSERT_NEXT(a_out_sets_valid, state_reg == StOut, m_axis_tvalid)
    `MKX_ASSERT_NEXT(a_key_then_fb, state_reg == StKey && core_done && !kphase_reg, 1'b0)
endmodule

// File: hdl/mkx_md5_core.sv
// iterative md5 of one padded short block, one round per cycle
// message is an 8-byte key or a 16-byte digest; uses mkx_pkg
`timescale 1ns / 1ps
module mkx_md5_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mkx_pkg::md5_ctl_t    ctl,
    input  mkx_pkg::digest_t     msg,
    output logic                 done,
    output mkx_pkg::digest_t     digest
);
    import mkx_pkg::*;

    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hefcdab89;
    localparam word_t H2 = 32'h98badcfe;
    localparam word_t H3 = 32'h10325476;

    logic        busy_reg;
    logic [5:0]  round_reg;
    logic        done_reg;
    word_t       a_reg, b_reg, c_reg, d_reg;
    word_t       blk_reg [16];
    word_t       blk_init [16];
    digest_t     digest_reg;

    word_t       f, sum, rot, m_word;
    logic [3:0]  g;
    logic [4:0]  sh;
    logic [5:0]  r5, r3, r7;

    always_comb
    begin
        r5 = round_reg * 6'd5 + 6'd1;
        r3 = round_reg * 6'd3 + 6'd5;
        r7 = round_reg * 6'd7;
        case (round_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = round_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = r5[3:0];
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = r3[3:0];
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = r7[3:0];
            end
        endcase
        m_word = blk_reg[g];
        sh = md5_s({round_reg[5:4], round_reg[1:0]});
        sum = a_reg + f + md5_k(round_reg) + m_word;
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // padded block for the key or digest message
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_init[i] = '0;
        end
        blk_init[0] = msg[31:0];
        blk_init[1] = msg[63:32];
        if (ctl.key_msg)
        begin
            blk_init[2]  = 32'h00000080;
            blk_init[14] = 32'd64;
        end
        else
        begin
            blk_init[2]  = msg[95:64];
            blk_init[3]  = msg[127:96];
            blk_init[4]  = 32'h00000080;
            blk_init[14] = 32'd128;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(RoundCount - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= H0;
            b_reg <= H1;
            c_reg <= H2;
            d_reg <= H3;
            for (int i = 0; i < 16; i++)
            begin
                blk_reg[i] <= blk_init[i];
            end
        end
        else if (busy_reg)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
            if (round_reg == 6'(RoundCount - 1))
            begin
                digest_reg <= {c_reg + H3, b_reg + H2, b_reg + rot + H1, d_reg + H0};
            end
        end
    end

    assign done   = done_reg;
    assign digest = digest_reg;
endmodule

// File: sim/md5_keystream_xor_cipher_chk.sv
// checker for the md5 keystream cipher: watches cfg, s_axis and m_axis,
// predicts each output beat with its own md5 and compares; no dependencies
`timescale 1ns / 1ps
module md5_keystream_xor_cipher_chk
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          err_count,
    output int          pending
);
    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last;
    } cipher_beat_t;

    logic [31:0]    round_const [64];
    int unsigned    rot_amount [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                        4, 11, 16, 23, 6, 10, 15, 21};
    cipher_beat_t   expected_beats [$];
    logic [63:0]    key_copy;
    logic [127:0]   feedback_digest;
    logic [3:0]     group_pos;
    logic           at_buffer_start;

    initial
    begin
        real s;
        for (int i = 0; i < 64; i++)
        begin
            s = $sin(i + 1);
            if (s < 0.0)
                s = -s;
            round_const[i] = 32'(longint'($floor(s * 4294967296.0)));
        end
    end

    // md5 of a short message held in the low nbytes of msg, little-endian bytes
    function automatic logic [127:0] md5_short_msg(input logic [127:0] msg,
                                                   input int nbytes);
        logic [511:0] blk;
        logic [31:0]  h0, h1, h2, h3, a, b, c, d, f, t, sum;
        int           g;
        int unsigned  sh;
        blk = '0;
        for (int i = 0; i < nbytes; i++)
            blk[8*i +: 8] = msg[8*i +: 8];
        blk[8*nbytes +: 8] = 8'h80;
        blk[448 +: 64] = 64'(nbytes * 8);
        h0 = 32'h67452301;
        h1 = 32'hefcdab89;
        h2 = 32'h98badcfe;
        h3 = 32'h10325476;
        a = h0;
        b = h1;
        c = h2;
        d = h3;
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                f = (b & c) | (~b & d);
                g = i;
            end
            else if (i < 32)
            begin
                f = (d & b) | (~d & c);
                g = (5 * i + 1) % 16;
            end
            else if (i < 48)
            begin
                f = b ^ c ^ d;
                g = (3 * i + 5) % 16;
            end
            else
            begin
                f = c ^ (b | ~d);
                g = (7 * i) % 16;
            end
            sum = a + f + round_const[i] + blk[32*g +: 32];
            sh = rot_amount[(i / 16) * 4 + (i % 4)];
            t = d;
            d = c;
            c = b;
            b = b + ((sum << sh) | (sum >> (32 - sh)));
            a = t;
        end
        return {h3 + d, h2 + c, h1 + b, h0 + a};
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        err_count++;
    endtask

    assign pending = expected_beats.size();

    always @(posedge clk or negedge rst_n)
    begin
        cipher_beat_t exp_b;
        if (!rst_n)
        begin
            key_copy <= '0;
            feedback_digest <= '0;
            group_pos <= '0;
            at_buffer_start <= 1'b1;
            err_count <= 0;
            expected_beats.delete();
        end
        else
        begin
            logic [127:0] dig;
            logic [3:0]   pos;
            if (cfg_we)
                key_copy <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                dig = feedback_digest;
                pos = group_pos;
                if (at_buffer_start)
                begin
                    dig = md5_short_msg({64'd0, key_copy}, 8);
                    pos = '0;
                end
                if (pos == 0)
                    dig = md5_short_msg(dig, 16);
                expected_beats.push_back('{s_axis_tdata ^ dig[8*pos +: 8], s_axis_tlast});
                feedback_digest <= dig;
                at_buffer_start <= s_axis_tlast;
                group_pos <= s_axis_tlast ? 4'd0 : pos + 4'd1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                    report_mismatch("output beat with nothing expected");
                else
                begin
                    exp_b = expected_beats.pop_front();
                    if (m_axis_tdata !== exp_b.cipher_byte)
                        report_mismatch($sformatf("byte %02h, expected %02h",
                                                  m_axis_tdata, exp_b.cipher_byte));
                    if (m_axis_tlast !== exp_b.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_axis_tlast, exp_b.last));
                end
            end
        end
    end
endmodule

// File: sim/md5_keystream_xor_cipher_tb.sv
// testbench top for the md5 keystream cipher: clock, reset, stimulus, verdict
// uses md5_keystream_xor_cipher and md5_keystream_xor_cipher_chk
`timescale 1ns / 1ps
module md5_keystream_xor_cipher_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    int          err_count;
    int          pending;
    logic        idle_on = 1'b1;
    logic        hold_go = 1'b0;
    int          bytes_sent = 0;

    always #5 clk = ~clk;

    md5_keystream_xor_cipher i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),     // data_byte
        .s_axis_tlast(s_axis_tlast),     // last_byte
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),     // out_byte
        .m_axis_tlast(m_axis_tlast)      // out_last
    );

    md5_keystream_xor_cipher_chk i_chk
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .err_count(err_count),
        .pending(pending)
    );

    task automatic send_byte(input logic [7:0] d, input logic l);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tlast <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
    endtask

    // key writes only once every result is back and the core has settled
    task automatic load_key(input logic [63:0] k);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (140) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_buffer(input int len, input logic close);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), close && (i == len - 1));
    endtask

    task automatic random_phase(input int target);
        int len;
        while (bytes_sent < target)
        begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(40, 70);
                1, 2:    len = 1;
                default: len = $urandom_range(2, 34);
            endcase
            // rare open buffers run on into the next one
            send_buffer(len, $urandom_range(0, 7) != 0);
        end
    endtask

    always
    begin
        @(posedge clk);
        if (hold_go)
        begin
            m_axis_tready <= 1'b0;
            repeat (600) @(posedge clk);
            hold_go = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        else
            m_axis_tready <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("md5_keystream_xor_cipher_tb: FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset key, single-byte buffers at the data extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        load_key(64'hffff_ffff_ffff_ffff);
        send_byte(8'hff, 1'b1);
        // key change in the middle of an open buffer
        for (int i = 0; i < 5; i++)
            send_byte(8'(i * 8'h55), 1'b0);
        load_key(64'h0123_4567_89ab_cdef);
        for (int i = 0; i < 13; i++)
            send_byte(8'($urandom), i == 12);
        send_byte(8'h5a, 1'b1);
        hold_go = 1'b1;
        random_phase(500);
        load_key(64'd0);
        random_phase(900);
        load_key({$urandom, $urandom});
        random_phase(1350);
        load_key(64'hffff_ffff_ffff_ffff);
        idle_on = 1'b0;
        random_phase(1850);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (150) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("md5_keystream_xor_cipher_tb: PASS");
        else
            $display("md5_keystream_xor_cipher_tb: FAIL");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/mkx_pkg.sv
hdl/mkx_md5_core.sv
hdl/md5_keystream_xor_cipher.sv
sim/md5_keystream_xor_cipher_chk.sv
sim/md5_keystream_xor_cipher_tb.sv
